// ===== rtl/core/akvt_pkg.sv =====
// Shared types and codes for the associative key/value table.
package akvt_pkg;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_EXISTS = 3'd3,
    CMD_COUNT  = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

endpackage

// ===== rtl/core/associative_key_value_table_unit.sv =====
// Top level of the fully associative key/value table.
//
// An item is a command with a key and a value, taken when start is high and
// busy is low. Commands are set, get, remove, exists, count and clear.
// Set, get, remove and exists walk all CAPACITY entries through one shared
// comparator, one entry per cycle behind the registered memory read, then
// decide and write back. Count, clear and unused codes skip the scan and go
// straight to the decide step. The memory read port and the single comparator
// set the length of the scan. Busy is high from accept until the result.
// Each result stands on status_o, found_o, value_out_o and entry_total_o for
// exactly one cycle with done_o high; the receiver cannot stall it, and a new
// item may be started in that same cycle.
// Reset clears every valid bit and the entry count at once, so the table is
// empty and ready in the first cycle after reset.
module associative_key_value_table_unit #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic [63:0]        key_i,
  input  logic signed [31:0] value_in_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic signed [31:0] value_out_o,
  output logic [4:0]         entry_total_o
);

  import akvt_pkg::*;

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [2:0]            cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CntW-1:0]       scan_q, scan_d;
  logic                  cmp_en_q, cmp_en_d;
  logic [IdxW-1:0]       cmp_idx_q;
  logic [CAPACITY-1:0]   valid_q, valid_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic                  found_q, found_d;
  logic [31:0]           vout_q, vout_d;

  logic                  accept, load, init, rd_en;
  logic                  wr_key_en, wr_val_en;
  logic [IdxW-1:0]       wr_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  hit, free;
  logic [IdxW-1:0]       hit_idx, free_idx;
  logic [VALUE_BITS-1:0] hit_val;
  logic signed [VALUE_BITS-1:0] hit_val_s;
  logic [63:0]           vin_wide, vout_wide;
  logic [31:0]           total_wide;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign vin_wide  = 64'(value_in_i);
  assign hit_val_s = hit_val;
  assign vout_wide = 64'(hit_val_s);

  akvt_store #(
    .Depth(CAPACITY),
    .KeyW (KEY_BITS),
    .ValW (VALUE_BITS),
    .IdxW (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_key_en_i(wr_key_en),
    .wr_val_en_i(wr_val_en),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (key_q),
    .wr_val_i   (val_q),
    .rd_en_i    (rd_en),
    .rd_addr_i  (scan_q[IdxW-1:0]),
    .rd_key_o   (rd_key),
    .rd_val_o   (rd_val)
  );

  akvt_match #(
    .KeyW(KEY_BITS),
    .ValW(VALUE_BITS),
    .IdxW(IdxW)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (init),
    .cmp_en_i   (cmp_en_q),
    .cmp_idx_i  (cmp_idx_q),
    .cmp_valid_i(valid_q[cmp_idx_q]),
    .cmp_key_i  (rd_key),
    .cmp_val_i  (rd_val),
    .key_i      (key_q),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .hit_val_o  (hit_val),
    .free_o     (free),
    .free_idx_o (free_idx)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (command_i <= CMD_EXISTS) ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (scan_q == CntW'(CAPACITY)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    load      = 1'b0;
    init      = 1'b0;
    rd_en     = 1'b0;
    scan_d    = scan_q;
    cmp_en_d  = 1'b0;
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    wr_addr   = hit_idx;
    valid_d   = valid_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    vout_d    = vout_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          load   = 1'b1;
          init   = 1'b1;
          scan_d = '0;
        end
      end
      S_SCAN: begin
        if (scan_q < CntW'(CAPACITY)) begin
          rd_en    = 1'b1;
          cmp_en_d = 1'b1;
          scan_d   = scan_q + CntW'(1);
        end
      end
      S_DECIDE: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        found_d  = 1'b0;
        vout_d   = '0;
        case (cmd_q)
          CMD_SET: begin
            found_d = hit;
            if (hit) begin
              wr_val_en = 1'b1;
              wr_addr   = hit_idx;
            end else if (free) begin
              wr_key_en         = 1'b1;
              wr_val_en         = 1'b1;
              wr_addr           = free_idx;
              valid_d[free_idx] = 1'b1;
              count_d           = count_q + CntW'(1);
            end else begin
              status_d = ST_FULL;
            end
          end
          CMD_GET: begin
            found_d = hit;
            if (hit) begin
              vout_d = vout_wide[31:0];
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          CMD_REMOVE: begin
            found_d = hit;
            if (hit) begin
              valid_d[hit_idx] = 1'b0;
              count_d          = count_q - CntW'(1);
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          CMD_EXISTS: begin
            found_d = hit;
          end
          CMD_CLEAR: begin
            valid_d = '0;
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scan_q   <= '0;
      cmp_en_q <= 1'b0;
      valid_q  <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      cmp_en_q <= cmp_en_d;
      valid_q  <= valid_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= command_i;
      key_q <= key_i[KEY_BITS-1:0];
      val_q <= vin_wide[VALUE_BITS-1:0];
    end
    cmp_idx_q <= scan_q[IdxW-1:0];
    status_q  <= status_d;
    found_q   <= found_d;
    vout_q    <= vout_d;
  end

  assign total_wide    = 32'(count_q);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign entry_total_o = total_wide[4:0];

endmodule

// ===== rtl/core/akvt_store.sv =====
// Key and value memory with one write port and one registered read port.
module akvt_store #(
  parameter int Depth = 16,
  parameter int KeyW  = 64,
  parameter int ValW  = 32,
  parameter int IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            wr_key_en_i,
  input  logic            wr_val_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [KeyW-1:0] wr_key_i,
  input  logic [ValW-1:0] wr_val_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [KeyW-1:0] rd_key_o,
  output logic [ValW-1:0] rd_val_o
);

  logic [KeyW-1:0] key_mem [Depth];
  logic [ValW-1:0] val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_key_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (wr_val_en_i) begin
      val_mem[wr_addr_i] <= wr_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_val_o <= val_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/akvt_match.sv =====
// Shared key comparator that tracks the matching entry and the first free slot.
module akvt_match #(
  parameter int KeyW = 64,
  parameter int ValW = 32,
  parameter int IdxW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_i,
  input  logic            cmp_en_i,
  input  logic [IdxW-1:0] cmp_idx_i,
  input  logic            cmp_valid_i,
  input  logic [KeyW-1:0] cmp_key_i,
  input  logic [ValW-1:0] cmp_val_i,
  input  logic [KeyW-1:0] key_i,
  output logic            hit_o,
  output logic [IdxW-1:0] hit_idx_o,
  output logic [ValW-1:0] hit_val_o,
  output logic            free_o,
  output logic [IdxW-1:0] free_idx_o
);

  logic            hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [ValW-1:0] hit_val_q;
  logic            is_hit, is_free;

  assign is_hit  = cmp_en_i && cmp_valid_i && (cmp_key_i == key_i);
  assign is_free = cmp_en_i && !cmp_valid_i && !free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (init_i) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (is_hit) begin
        hit_q <= 1'b1;
      end
      if (is_free) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_hit) begin
      hit_idx_q <= cmp_idx_i;
      hit_val_q <= cmp_val_i;
    end
    if (is_free) begin
      free_idx_q <= cmp_idx_i;
    end
  end

  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;
  assign hit_val_o  = hit_val_q;
  assign free_o     = free_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== tb/akvt_checker.sv =====
// Checker that predicts each key/value table reply and compares it with the block's result.
`timescale 1ns / 1ps
module akvt_checker #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         command_i,
  input  logic [63:0]        key_i,
  input  logic signed [31:0] value_in_i,
  input  logic               done_o,
  input  logic [1:0]         status_o,
  input  logic               found_o,
  input  logic signed [31:0] value_out_o,
  input  logic [4:0]         entry_total_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  import akvt_pkg::*;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [63:0]        key;
    status_e            status;
    logic               found;
    logic signed [31:0] value_out;
    logic [4:0]         entry_total;
  } table_reply_t;

  logic [63:0]         slot_key   [CAPACITY];
  logic signed [31:0]  slot_value [CAPACITY];
  logic [CAPACITY-1:0] slot_valid;
  logic [4:0]          occupied;
  table_reply_t        expected_replies [$];
  int                  fail_count;

  function automatic table_reply_t apply_table_command(logic [2:0] cmd, logic [63:0] key,
                                                       logic signed [31:0] value);
    table_reply_t r;
    int hit_idx;
    int free_idx;
    r = '0;
    r.cmd = cmd;
    r.key = key;
    r.status = ST_OK;
    hit_idx = -1;
    free_idx = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_valid[i] && slot_key[i] == key && hit_idx < 0) hit_idx = i;
      if (!slot_valid[i] && free_idx < 0) free_idx = i;
    end
    case (cmd)
      CMD_SET: begin
        r.found = (hit_idx >= 0);
        if (hit_idx >= 0) begin
          slot_value[hit_idx] = value;
        end else if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_key[free_idx]   = key;
          slot_value[free_idx] = value;
          slot_valid[free_idx] = 1'b1;
          occupied = occupied + 5'd1;
        end
      end
      CMD_GET: begin
        r.found = (hit_idx >= 0);
        if (hit_idx >= 0) r.value_out = slot_value[hit_idx];
        else r.status = ST_NOT_FOUND;
      end
      CMD_REMOVE: begin
        r.found = (hit_idx >= 0);
        if (hit_idx >= 0) begin
          slot_valid[hit_idx] = 1'b0;
          occupied = occupied - 5'd1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      CMD_EXISTS: begin
        r.found = (hit_idx >= 0);
      end
      CMD_CLEAR: begin
        slot_valid = '0;
        occupied = '0;
      end
      default: begin
      end
    endcase
    r.entry_total = occupied;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t exp_r;
    if (!rst_ni) begin
      slot_valid = '0;
      occupied = '0;
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (done_o) begin
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with no command pending", $realtime);
            $display("  actual   status=%0d found=%0d value=%0d total=%0d",
                     status_o, found_o, value_out_o, entry_total_o);
          end
        end else begin
          exp_r = expected_replies.pop_front();
          if (status_o !== exp_r.status || found_o !== exp_r.found ||
              value_out_o !== exp_r.value_out || entry_total_o !== exp_r.entry_total) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch cmd=%0d key=%h", $realtime, exp_r.cmd, exp_r.key);
              $display("  expected status=%0d found=%0d value=%0d total=%0d",
                       exp_r.status, exp_r.found, exp_r.value_out, exp_r.entry_total);
              $display("  actual   status=%0d found=%0d value=%0d total=%0d",
                       status_o, found_o, value_out_o, entry_total_o);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_replies.insert(expected_replies.size(),
                                apply_table_command(command_i, key_i, value_in_i));
      end
    end
    fail_count_o <= fail_count;
    pending_o <= expected_replies.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the key/value table testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import akvt_pkg::*;

  localparam int unsigned NUM_ITEMS   = 1850;
  localparam int unsigned CALM_ITEMS  = 200;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 30;

  localparam logic [2:0]         CMD_SPARE_LO = 3'd6;
  localparam logic [2:0]         CMD_SPARE_HI = 3'd7;
  localparam logic [63:0]        KEY_ONES     = '1;
  localparam logic signed [31:0] VALUE_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX    = 32'sh7FFF_FFFF;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic [2:0]         command_i  = '0;
  logic [63:0]        key_i      = '0;
  logic signed [31:0] value_in_i = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic               found_o;
  logic signed [31:0] value_out_o;
  logic [4:0]         entry_total_o;
  int                 fail_count;
  int                 pending;
  int unsigned        quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  associative_key_value_table_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .value_out_o  (value_out_o),
    .entry_total_o(entry_total_o)
  );

  akvt_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_o      (found_o),
    .value_out_o  (value_out_o),
    .entry_total_o(entry_total_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[associative_key_value_table_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] random_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [2:0] pick_command(bit set_heavy);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (set_heavy && roll < 55) return CMD_SET;
    if (roll < 35) return CMD_SET;
    if (roll < 55) return CMD_GET;
    if (roll < 67) return CMD_REMOVE;
    if (roll < 83) return CMD_EXISTS;
    if (roll < 95) return CMD_COUNT;
    if (roll < 97) return CMD_CLEAR;
    return roll[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [63:0] key,
                          input logic signed [31:0] value);
    start      <= 1'b1;
    command_i  <= cmd;
    key_i      <= key;
    value_in_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(input bit wait_result);
    int unsigned gap;
    gap = $urandom_range(1, 7);
    start <= 1'b0;
    if (wait_result) begin
      do @(posedge clk_i); while (busy);
    end
    repeat (gap) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0]        key_pool [32];
    int unsigned        pool_size;
    int unsigned        sent;
    int unsigned        span;
    int unsigned        roll;
    bit                 set_heavy;
    bit                 idle_on;
    logic [2:0]         cmd;
    logic [63:0]        key;
    logic signed [31:0] value;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_COUNT, random_key(), $urandom());
    send_cmd(CMD_GET, '0, $urandom());
    send_cmd(CMD_REMOVE, KEY_ONES, $urandom());
    send_cmd(CMD_EXISTS, 64'h5, $urandom());
    send_cmd(CMD_SET, '0, VALUE_MIN);
    send_cmd(CMD_SET, KEY_ONES, VALUE_MAX);
    send_cmd(CMD_GET, '0, '0);
    send_cmd(CMD_GET, KEY_ONES, '0);
    send_cmd(CMD_SET, '0, -32'sd1);
    send_cmd(CMD_GET, '0, VALUE_MAX);
    send_cmd(CMD_EXISTS, KEY_ONES, '0);
    send_cmd(CMD_GET, 64'h8000_0000_0000_0000, '0);
    send_cmd(CMD_REMOVE, '0, '0);
    send_cmd(CMD_REMOVE, '0, '0);
    send_cmd(CMD_SPARE_LO, KEY_ONES, VALUE_MIN);
    send_cmd(CMD_SPARE_HI, '0, VALUE_MAX);
    send_cmd(CMD_COUNT, KEY_ONES, VALUE_MAX);
    send_cmd(CMD_CLEAR, KEY_ONES, VALUE_MIN);
    send_cmd(CMD_GET, KEY_ONES, '0);
    send_cmd(CMD_COUNT, '0, '0);

    sent = 0;
    while (sent < NUM_ITEMS) begin
      pool_size = $urandom_range(2, 28);
      for (int i = 0; i < pool_size; i++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) key_pool[i] = '0;
        else if (roll == 1) key_pool[i] = KEY_ONES;
        else if (roll < 4 && i > 0) key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
        else key_pool[i] = random_key();
      end
      set_heavy = ($urandom_range(0, 2) == 0);
      idle_on   = ($urandom_range(0, 2) != 0);
      span      = $urandom_range(30, 120);
      for (int n = 0; n < span && sent < NUM_ITEMS; n++) begin
        cmd = pick_command(set_heavy);
        if ($urandom_range(0, 9) == 0) key = random_key();
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        roll = $urandom_range(0, 15);
        if (roll == 0) value = VALUE_MIN;
        else if (roll == 1) value = VALUE_MAX;
        else if (roll == 2) value = '0;
        else if (roll == 3) value = -32'sd1;
        else value = $urandom();
        send_cmd(cmd, key, value);
        if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) sent++;
        if (idle_on && sent + CALM_ITEMS < NUM_ITEMS && $urandom_range(0, 2) == 0) begin
          pause_sender($urandom_range(0, 1));
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[associative_key_value_table_unit] OK");
    end else begin
      $display("[associative_key_value_table_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/akvt_pkg.sv
rtl/core/akvt_store.sv
rtl/core/akvt_match.sv
rtl/core/associative_key_value_table_unit.sv
tb/akvt_checker.sv
tb/tb_top.sv
